// File: design/lrupr_pkg.sv
// Shared definitions for the LRU page replacement block.
// Holds default sizes, fixed port widths and the cell control struct.
// No dependencies.
package lrupr_pkg;

	localparam int FRAME_COUNT_DEF = 4;
	localparam int PAGE_BITS_DEF   = 8;

	localparam int PAGE_ID_W = 8;
	localparam int SLOT_W    = 2;
	localparam int HIT_W     = 32;

	typedef struct packed {
		logic take;
		logic hit;
		logic full_miss;
		logic fill;
	} cell_ctl_t;

endpackage

// File: design/lru_page_replacement.sv
// LRU page replacement over a small set of frames.
// Input channel: page_id with in_valid / in_stall; one page request per transaction.
// Output channel: is_hit, frame_slot, evicted_valid, evicted_page, hit_total with
// out_valid / out_stall; one result per request.
// The frames sit in a chain of cells ordered from least to most recently used.
// Every cell compares its page with the request at once; a hit or an eviction
// shifts the cells behind the chosen position one step toward the least recent
// end and the most recent cell takes the request. A miss with free frames fills
// the first empty cell.
// An accepted request has its result in the output register in the next cycle.
// Throughput: one request per cycle while the output is not stalled, set by the
// combinational compare and shift across the cell chain.
// hit_total counts hits since reset and saturates at its maximum.
// Reset empties all frames and clears the hit count; no clearing pass is needed.
// While the receiver stalls a waiting result, the result holds and in_stall
// rises; a request is still taken in the cycle the output register drains.
module lru_page_replacement #(
	parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
	parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lrupr_pkg::PAGE_ID_W-1:0] page_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            is_hit,
	output logic [lrupr_pkg::SLOT_W-1:0]    frame_slot,
	output logic                            evicted_valid,
	output logic [lrupr_pkg::PAGE_ID_W-1:0] evicted_page,
	output logic [lrupr_pkg::HIT_W-1:0]     hit_total
);
	import lrupr_pkg::*;

	localparam int FIDX_W = $clog2(FRAME_COUNT);

	cell_ctl_t            ctl;
	logic [PAGE_BITS-1:0] req_page;
	logic                 hit;
	logic                 hit_any;
	logic                 full;
	logic [FIDX_W-1:0]    tail_frame;
	logic [FIDX_W-1:0]    slot;

	logic                 c_valid [FRAME_COUNT];
	logic [PAGE_BITS-1:0] c_page  [FRAME_COUNT];
	logic [FIDX_W-1:0]    c_frame [FRAME_COUNT];
	logic                 sh      [FRAME_COUNT+1];
	logic [FIDX_W-1:0]    hfr     [FRAME_COUNT+1];
	logic [FIDX_W-1:0]    ffr     [FRAME_COUNT+1];

	logic                 out_valid_q;
	logic                 is_hit_q;
	logic [SLOT_W-1:0]    frame_slot_q;
	logic                 evicted_valid_q;
	logic [PAGE_ID_W-1:0] evicted_page_q;
	logic [HIT_W-1:0]     hit_cnt_q;

	assign req_page = PAGE_BITS'(page_id);
	assign in_stall = out_valid_q & out_stall;
	assign full     = c_valid[FRAME_COUNT-1];
	assign hit      = sh[FRAME_COUNT] & ~sh[0];

	assign ctl.take      = in_valid & ~in_stall;
	assign ctl.full_miss = sh[0];
	assign ctl.hit       = hit;
	assign ctl.fill      = ~hit & ~full;

	assign sh[0]      = full & ~hit_any;
	assign hfr[0]     = '0;
	assign ffr[0]     = '0;
	assign tail_frame = hit_any ? hfr[FRAME_COUNT] : c_frame[0];

	always_comb begin
		hit_any = 1'b0;
		for (int i = 0; i < FRAME_COUNT; i++) begin
			hit_any = hit_any | (c_valid[i] && (c_page[i] == req_page));
		end
	end

	always_comb begin
		if (hit_any) begin
			slot = hfr[FRAME_COUNT];
		end else if (full) begin
			slot = c_frame[0];
		end else begin
			slot = ffr[FRAME_COUNT];
		end
	end

	for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
		logic left_v;
		logic right_v;
		logic [PAGE_BITS-1:0] right_p;
		logic [FIDX_W-1:0]    right_f;

		if (g == 0) begin : g_first
			assign left_v = 1'b1;
		end else begin : g_mid
			assign left_v = c_valid[g-1];
		end

		if (g == FRAME_COUNT - 1) begin : g_last
			assign right_v = 1'b0;
			assign right_p = '0;
			assign right_f = '0;
		end else begin : g_inner
			assign right_v = c_valid[g+1];
			assign right_p = c_page[g+1];
			assign right_f = c_frame[g+1];
		end

		lrupr_cell #(
			.FRAME_COUNT (FRAME_COUNT),
			.PAGE_BITS   (PAGE_BITS),
			.CELL_IDX    (g)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.req_page       (req_page),
			.tail_frame     (tail_frame),
			.left_valid     (left_v),
			.right_valid    (right_v),
			.right_page     (right_p),
			.right_frame    (right_f),
			.sh_in          (sh[g]),
			.sh_out         (sh[g+1]),
			.hit_frame_in   (hfr[g]),
			.hit_frame_out  (hfr[g+1]),
			.free_frame_in  (ffr[g]),
			.free_frame_out (ffr[g+1]),
			.cell_valid     (c_valid[g]),
			.cell_page      (c_page[g]),
			.cell_frame     (c_frame[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
		end else begin
			out_valid_q <= ctl.take | (out_valid_q & out_stall);
			if (ctl.take && hit_any && (hit_cnt_q != {HIT_W{1'b1}})) begin
				hit_cnt_q <= hit_cnt_q + HIT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			is_hit_q        <= hit_any;
			frame_slot_q    <= SLOT_W'(slot);
			evicted_valid_q <= ~hit_any & full;
			evicted_page_q  <= (~hit_any & full) ? PAGE_ID_W'(c_page[0]) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_hit        = is_hit_q;
	assign frame_slot    = frame_slot_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign hit_total     = hit_cnt_q;

endmodule

// File: design/lrupr_cell.sv
// One recency position of the LRU chain: holds a resident page and its frame.
// Shifts toward the least recent end on a hit or eviction, fills on a free miss.
// Depends on lrupr_pkg.
module lrupr_cell #(
	parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
	parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF,
	parameter int CELL_IDX    = 0,
	localparam int FIDX_W     = $clog2(FRAME_COUNT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrupr_pkg::cell_ctl_t  ctl,
	input  logic [PAGE_BITS-1:0]  req_page,
	input  logic [FIDX_W-1:0]     tail_frame,
	input  logic                  left_valid,
	input  logic                  right_valid,
	input  logic [PAGE_BITS-1:0]  right_page,
	input  logic [FIDX_W-1:0]     right_frame,
	input  logic                  sh_in,
	output logic                  sh_out,
	input  logic [FIDX_W-1:0]     hit_frame_in,
	output logic [FIDX_W-1:0]     hit_frame_out,
	input  logic [FIDX_W-1:0]     free_frame_in,
	output logic [FIDX_W-1:0]     free_frame_out,
	output logic                  cell_valid,
	output logic [PAGE_BITS-1:0]  cell_page,
	output logic [FIDX_W-1:0]     cell_frame
);
	import lrupr_pkg::*;

	logic                 valid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [FIDX_W-1:0]    frame_q;
	logic                 match;
	logic                 last;
	logic                 free_here;

	assign match          = valid_q && (page_q == req_page);
	assign sh_out         = sh_in | match;
	assign last           = valid_q & ~right_valid;
	assign free_here      = ~valid_q & left_valid;
	assign hit_frame_out  = hit_frame_in | (match ? frame_q : '0);
	assign free_frame_out = free_frame_in | (free_here ? FIDX_W'(CELL_IDX) : '0);

	assign cell_valid = valid_q;
	assign cell_page  = page_q;
	assign cell_frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.take && ctl.fill && free_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if ((ctl.hit || ctl.full_miss) && sh_out) begin
				if (last) begin
					page_q  <= req_page;
					frame_q <= tail_frame;
				end else begin
					page_q  <= right_page;
					frame_q <= right_frame;
				end
			end else if (ctl.fill && free_here) begin
				page_q  <= req_page;
				frame_q <= FIDX_W'(CELL_IDX);
			end
		end
	end

endmodule
